// File: rtl/hts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the heightfield triangle sampler.
package hts_pkg;

   localparam int DIM_W         = 9;
   localparam int SUB_W         = 5;
   localparam int HEIGHT_W      = 24;
   localparam int COORD_W       = 16;
   localparam int SAMPLE_ADDR_W = 13;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam int STORE_DEPTH_DEFAULT = 8192;

   // Grid offset (x + 128*W) for an in-range point, its scaled form, and sample indexes.
   localparam int OFF_W  = 17;
   localparam int XH_W   = OFF_W + SUB_W;
   localparam int FRAC_W = 8;
   localparam int IDX_W  = XH_W - FRAC_W;
   localparam int LIN_W  = 2 * IDX_W;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_CELLS_WIDE   = 2'd0;
   localparam logic [1:0] REG_CELLS_DEEP   = 2'd1;
   localparam logic [1:0] REG_SUBDIVISIONS = 2'd2;

   localparam logic [DIM_W-1:0] CELLS_WIDE_RESET   = 9'd70;
   localparam logic [DIM_W-1:0] CELLS_DEEP_RESET   = 9'd70;
   localparam logic [SUB_W-1:0] SUBDIVISIONS_RESET = 5'd1;

   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 24'sh800000;

   typedef struct packed {
      logic                              opcode;
      logic [SAMPLE_ADDR_W-1:0]          sample_address;
      logic signed [HEIGHT_W-1:0]        sample_height;
      logic signed [COORD_W-1:0]         query_x;
      logic signed [COORD_W-1:0]         query_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0]        height;
      logic                              out_of_range;
   } rsp_payload_type;

endpackage

// File: rtl/hts_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
module hts_ram #(
   parameter int WIDTH = hts_pkg::HEIGHT_W,
   parameter int DEPTH = hts_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/hts_addr_wrap.sv
`timescale 1ns / 1ps
// Three-stage pipeline that reduces a linear sample index modulo the store depth.
module hts_addr_wrap #(
   parameter int DEPTH = hts_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [hts_pkg::LIN_W-1:0] in_lin,
   output logic                      out_valid,
   output logic [$clog2(DEPTH)-1:0]  out_addr
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = hts_pkg::LIN_W;
   localparam int K  = LW + AW;
   localparam int RW = LW + 2;
   localparam int QW = LW - AW + 1;
   localparam int PW = LW + RW;
   // With K = LW + clog2(DEPTH) the rounded-up reciprocal gives an exact quotient.
   localparam longint unsigned RECIP = ((64'd1 << K) / DEPTH) + 64'd1;
   localparam logic [RW-1:0]   RECIP_V = RW'(RECIP);
   localparam logic [AW:0]     DEPTH_V = (AW + 1)'(DEPTH);

   logic [2:0]    valid_ff;
   logic [PW-1:0] prod_ff;
   logic [LW-1:0] lin1_ff;
   logic [LW-1:0] lin2_ff;
   logic [LW-1:0] qm_ff;
   logic [AW-1:0] rem_ff;
   logic [QW-1:0] quot;
   logic [LW-1:0] rem_full;

   assign quot     = prod_ff[K +: QW];
   assign rem_full = lin2_ff - qm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(in_lin) * PW'(RECIP_V);
      lin1_ff <= in_lin;
      qm_ff   <= LW'(LW'(quot) * LW'(DEPTH_V));
      lin2_ff <= lin1_ff;
      rem_ff  <= rem_full[AW-1:0];
   end

   assign out_valid = valid_ff[2];
   assign out_addr  = rem_ff;

endmodule

// File: rtl/heightfield_triangle_sampler.sv
`timescale 1ns / 1ps
// Heightfield triangle sampler: a write transfer (opcode 0) stores one signed Q.8 height
// sample in a single-port store of STORE_DEPTH entries, with no result. A query
// transfer (opcode 1) returns one result: the height at (x,z) interpolated over the cell
// triangle that holds the point, or 0 with out_of_range set when the point lies outside
// the grid. A query in range passes through range check, scaling and index arithmetic;
// then three corner addresses pass one per cycle through a three-stage modulo-depth
// reduction pipeline and are read from the single memory port; then interpolation and
// output follow. An out-of-range query goes from the range check straight to output. A
// query whose result finds the output register still occupied holds in its output state
// until that register drains. The block takes one item at a time; a finished result
// waits in an output register while the next item is accepted. Registers (cells_wide,
// cells_deep, subdivisions) sit at byte addresses 0, 4 and 8 and may only be written
// while the block is idle.
module heightfield_triangle_sampler #(
   parameter int STORE_DEPTH = hts_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hts_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hts_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hts_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hts_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int AW     = $clog2(STORE_DEPTH);
   localparam int DW     = hts_pkg::DIM_W;
   localparam int SW     = hts_pkg::SUB_W;
   localparam int HW     = hts_pkg::HEIGHT_W;
   localparam int CW     = hts_pkg::COORD_W;
   localparam int OW     = hts_pkg::OFF_W;
   localparam int XW     = hts_pkg::XH_W;
   localparam int FW     = hts_pkg::FRAC_W;
   localparam int IW     = hts_pkg::IDX_W;
   localparam int LW     = hts_pkg::LIN_W;
   localparam int DIFF_W = HW + 1;
   localparam int PROD_W = DIFF_W + FW + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int INT_W  = SUM_W - FW + 1;

   localparam logic [1:0] CORNER_COUNT = 2'd3;
   localparam logic [1:0] LAST_CORNER  = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_RANGE   = 11'b00000000010,
      S_SCALE   = 11'b00000000100,
      S_CELL    = 11'b00000001000,
      S_ROWBASE = 11'b00000010000,
      S_LINEAR  = 11'b00000100000,
      S_ISSUE   = 11'b00001000000,
      S_DIFF    = 11'b00010000000,
      S_MUL     = 11'b00100000000,
      S_SUM     = 11'b01000000000,
      S_OUT     = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [DW-1:0] cells_wide_ff;
   logic [DW-1:0] cells_deep_ff;
   logic [SW-1:0] subdivisions_ff;
   logic          csr_write;
   logic [1:0]    csr_index;

   // Query datapath registers.
   logic signed [CW-1:0]     query_x_ff;
   logic signed [CW-1:0]     query_z_ff;
   logic                     oor_ff, oor_in;
   logic [OW-1:0]            off_x_ff, off_z_ff;
   logic [XW-1:0]            xh_ff, zh_ff;
   logic [IW-1:0]            ncol_ff, nrow_ff;
   logic [IW-1:0]            c0_ff, c1_ff, r0_ff, r1_ff;
   logic                     upper_ff;
   logic [FW-1:0]            wb_ff, wc_ff;
   logic [LW-1:0]            rb0_ff, rb1_ff;
   logic [LW-1:0]            lin0_ff, lin1_ff, lin2_ff;
   logic [1:0]               issue_cnt_ff, ret_cnt_ff;
   logic                     rd_pending_ff;
   logic signed [HW-1:0]     corner_base_ff, corner_b_ff, corner_c_ff;
   logic signed [DIFF_W-1:0] diff_b_ff, diff_c_ff;
   logic signed [PROD_W-1:0] prod_b_ff, prod_c_ff;
   logic signed [SUM_W-1:0]  sum_ff;

   logic                     rsp_valid_ff;
   hts_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Combinational helpers.
   logic [DW-1:0]            w_eff, d_eff;
   logic [SW-1:0]            s_eff;
   logic signed [OW:0]       x_ext, z_ext, lim_x, lim_z, off_x, off_z;
   logic                     x_out, z_out;
   logic [IW-1:0]            col, row, ncol_m1, nrow_m1, c0, c1, r0, r1;
   logic [IW:0]              col_p1, row_p1;
   logic [FW-1:0]            fx, fz;
   logic                     upper;
   logic [FW:0]              frac_sum, inv_fx, inv_fz;
   logic                     write_accept, query_accept;
   logic                     mod_in_valid, mod_out_valid;
   logic [LW-1:0]            mod_in_lin;
   logic [AW-1:0]            mod_addr;
   logic                     ram_en, ram_we;
   logic [AW-1:0]            ram_addr;
   logic [HW-1:0]            ram_rdata;
   logic signed [INT_W-1:0]  interp;
   logic signed [HW-1:0]     height_sat;
   logic                     rsp_load;

   // ---------------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_wide_ff   <= hts_pkg::CELLS_WIDE_RESET;
         cells_deep_ff   <= hts_pkg::CELLS_DEEP_RESET;
         subdivisions_ff <= hts_pkg::SUBDIVISIONS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hts_pkg::REG_CELLS_WIDE:   cells_wide_ff   <= csr_pwdata[DW-1:0];
            hts_pkg::REG_CELLS_DEEP:   cells_deep_ff   <= csr_pwdata[DW-1:0];
            hts_pkg::REG_SUBDIVISIONS: subdivisions_ff <= csr_pwdata[SW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         hts_pkg::REG_CELLS_WIDE:   csr_prdata = hts_pkg::CSR_DATA_W'(cells_wide_ff);
         hts_pkg::REG_CELLS_DEEP:   csr_prdata = hts_pkg::CSR_DATA_W'(cells_deep_ff);
         hts_pkg::REG_SUBDIVISIONS: csr_prdata = hts_pkg::CSR_DATA_W'(subdivisions_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // A register value of zero behaves as one.
   assign w_eff = (cells_wide_ff == '0) ? DW'(1) : cells_wide_ff;
   assign d_eff = (cells_deep_ff == '0) ? DW'(1) : cells_deep_ff;
   assign s_eff = (subdivisions_ff == '0) ? SW'(1) : subdivisions_ff;

   // ---------------------------------------------------------------- handshake
   assign req_ready    = (state_ff == S_IDLE);
   assign write_accept = req_valid & req_ready & (req_payload.opcode == hts_pkg::OP_WRITE)
                         & (32'(req_payload.sample_address) < 32'(STORE_DEPTH));
   assign query_accept = req_valid & req_ready & (req_payload.opcode == hts_pkg::OP_QUERY);

   always_ff @(posedge clock) begin
      if (query_accept) begin
         query_x_ff <= req_payload.query_x;
         query_z_ff <= req_payload.query_z;
      end
   end

   // ---------------------------------------------------------------- range and cell
   assign x_ext = (OW + 1)'(query_x_ff);
   assign z_ext = (OW + 1)'(query_z_ff);
   assign lim_x = $signed({2'b00, w_eff, 7'b0000000});
   assign lim_z = $signed({2'b00, d_eff, 7'b0000000});
   assign off_x = x_ext + lim_x;
   assign off_z = z_ext + lim_z;
   assign x_out = off_x[OW] | (x_ext > lim_x);
   assign z_out = off_z[OW] | (z_ext > lim_z);
   assign oor_in = x_out | z_out;

   assign col      = xh_ff[XW-1:FW];
   assign row      = zh_ff[XW-1:FW];
   assign fx       = xh_ff[FW-1:0];
   assign fz       = zh_ff[FW-1:0];
   assign ncol_m1  = ncol_ff - IW'(1);
   assign nrow_m1  = nrow_ff - IW'(1);
   assign col_p1   = {1'b0, col} + (IW + 1)'(1);
   assign row_p1   = {1'b0, row} + (IW + 1)'(1);
   assign c0       = (col < ncol_m1) ? col : ncol_m1;
   assign r0       = (row < nrow_m1) ? row : nrow_m1;
   assign c1       = (col_p1 < {1'b0, ncol_m1}) ? col_p1[IW-1:0] : ncol_m1;
   assign r1       = (row_p1 < {1'b0, nrow_m1}) ? row_p1[IW-1:0] : nrow_m1;
   assign frac_sum = {1'b0, fx} + {1'b0, fz};
   assign upper    = frac_sum > (FW + 1)'(256);
   // In the upper triangle both fractions are nonzero, so the weights fit in eight bits.
   assign inv_fx   = (FW + 1)'(256) - {1'b0, fx};
   assign inv_fz   = (FW + 1)'(256) - {1'b0, fz};

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_RANGE: begin
            oor_ff   <= oor_in;
            off_x_ff <= off_x[OW-1:0];
            off_z_ff <= off_z[OW-1:0];
         end
         S_SCALE: begin
            xh_ff   <= XW'(off_x_ff) * XW'(s_eff);
            zh_ff   <= XW'(off_z_ff) * XW'(s_eff);
            ncol_ff <= IW'(w_eff) * IW'(s_eff);
            nrow_ff <= IW'(d_eff) * IW'(s_eff);
         end
         S_CELL: begin
            c0_ff    <= c0;
            c1_ff    <= c1;
            r0_ff    <= r0;
            r1_ff    <= r1;
            upper_ff <= upper;
            wb_ff    <= upper ? inv_fz[FW-1:0] : fx;
            wc_ff    <= upper ? inv_fx[FW-1:0] : fz;
         end
         S_ROWBASE: begin
            rb0_ff <= LW'(r0_ff) * LW'(ncol_ff);
            rb1_ff <= LW'(r1_ff) * LW'(ncol_ff);
         end
         S_LINEAR: begin
            lin0_ff <= upper_ff ? (rb1_ff + LW'(c1_ff)) : (rb0_ff + LW'(c0_ff));
            lin1_ff <= rb0_ff + LW'(c1_ff);
            lin2_ff <= rb1_ff + LW'(c0_ff);
         end
         S_DIFF: begin
            diff_b_ff <= DIFF_W'(corner_b_ff) - DIFF_W'(corner_base_ff);
            diff_c_ff <= DIFF_W'(corner_c_ff) - DIFF_W'(corner_base_ff);
         end
         S_MUL: begin
            prod_b_ff <= PROD_W'(diff_b_ff) * PROD_W'($signed({1'b0, wb_ff}));
            prod_c_ff <= PROD_W'(diff_c_ff) * PROD_W'($signed({1'b0, wc_ff}));
         end
         S_SUM: begin
            sum_ff <= SUM_W'(prod_b_ff) + SUM_W'(prod_c_ff);
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- corner reads
   always_comb begin
      case (issue_cnt_ff)
         2'd0:    mod_in_lin = lin0_ff;
         2'd1:    mod_in_lin = lin1_ff;
         default: mod_in_lin = lin2_ff;
      endcase
   end

   assign mod_in_valid = (state_ff == S_ISSUE) && (issue_cnt_ff != CORNER_COUNT);

   hts_addr_wrap #(
      .DEPTH (STORE_DEPTH)
   ) u_addr_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mod_in_valid),
      .in_lin    (mod_in_lin),
      .out_valid (mod_out_valid),
      .out_addr  (mod_addr)
   );

   assign ram_we   = write_accept;
   assign ram_en   = write_accept | mod_out_valid;
   assign ram_addr = write_accept ? AW'(req_payload.sample_address) : mod_addr;

   hts_ram #(
      .WIDTH (HW),
      .DEPTH (STORE_DEPTH)
   ) u_height_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_payload.sample_height),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff  <= '0;
         ret_cnt_ff    <= '0;
         rd_pending_ff <= 1'b0;
      end else begin
         rd_pending_ff <= mod_out_valid;
         if (state_ff == S_LINEAR) begin
            issue_cnt_ff <= '0;
            ret_cnt_ff   <= '0;
         end else begin
            if (mod_in_valid) begin
               issue_cnt_ff <= issue_cnt_ff + 2'd1;
            end
            if (rd_pending_ff) begin
               ret_cnt_ff <= ret_cnt_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pending_ff) begin
         case (ret_cnt_ff)
            2'd0:    corner_base_ff <= $signed(ram_rdata);
            2'd1:    corner_b_ff    <= $signed(ram_rdata);
            default: corner_c_ff    <= $signed(ram_rdata);
         endcase
      end
   end

   // ---------------------------------------------------------------- result
   // The arithmetic shift by eight is the floor division of the weighted sum.
   assign interp = INT_W'(corner_base_ff) + INT_W'($signed(sum_ff[SUM_W-1:FW]));

   always_comb begin
      if (interp > INT_W'(hts_pkg::HEIGHT_MAX)) begin
         height_sat = hts_pkg::HEIGHT_MAX;
      end else if (interp < INT_W'(hts_pkg::HEIGHT_MIN)) begin
         height_sat = hts_pkg::HEIGHT_MIN;
      end else begin
         height_sat = interp[HW-1:0];
      end
      rsp_payload_in.height       = oor_ff ? '0 : height_sat;
      rsp_payload_in.out_of_range = oor_ff;
   end

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (query_accept) state_in = S_RANGE;
         S_RANGE:   state_in = oor_in ? S_OUT : S_SCALE;
         S_SCALE:   state_in = S_CELL;
         S_CELL:    state_in = S_ROWBASE;
         S_ROWBASE: state_in = S_LINEAR;
         S_LINEAR:  state_in = S_ISSUE;
         S_ISSUE:   if (rd_pending_ff && (ret_cnt_ff == LAST_CORNER)) state_in = S_DIFF;
         S_DIFF:    state_in = S_MUL;
         S_MUL:     state_in = S_SUM;
         S_SUM:     state_in = S_OUT;
         S_OUT:     if (rsp_load) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // Reduced addresses only come back while the corner reads are in flight.
   a_wrap_in_issue: assert property (@(posedge clock) disable iff (reset)
      mod_out_valid |-> (state_ff == S_ISSUE))
      else $error("address pipeline output outside corner read phase");

   // No more than three corner samples return per query.
   a_ret_bounded: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |-> (ret_cnt_ff != CORNER_COUNT))
      else $error("too many corner reads returned");

   // Returns never run ahead of issued reads.
   a_ret_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> (ret_cnt_ff <= issue_cnt_ff))
      else $error("corner read returned before it was issued");

   // A new result appears only after the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output state");
`endif

endmodule

// File: dv/tb_heightfield_triangle_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the heightfield triangle sampler with a scoreboard class.
module tb_heightfield_triangle_sampler;
   import hts_pkg::*;

   localparam int STORE_DEPTH   = STORE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTING_COUNT = 10;

   class height_scoreboard;
      logic signed [HEIGHT_W-1:0] sample_mirror [STORE_DEPTH];
      bit                         sample_written [STORE_DEPTH];
      int unsigned                grid_wide;
      int unsigned                grid_deep;
      int unsigned                grid_sub;
      rsp_payload_type            expected_heights [$];
      int unsigned                mismatches;
      int unsigned                queries_seen;
      int unsigned                outside_seen;
      int unsigned                writes_seen;

      function new();
         grid_wide = CELLS_WIDE_RESET;
         grid_deep = CELLS_DEEP_RESET;
         grid_sub  = SUBDIVISIONS_RESET;
      endfunction

      function void set_register(logic [1:0] index, int unsigned value);
         case (index)
            REG_CELLS_WIDE:   grid_wide = value & 32'h1FF;
            REG_CELLS_DEEP:   grid_deep = value & 32'h1FF;
            REG_SUBDIVISIONS: grid_sub  = value & 32'h1F;
            default: ;
         endcase
      endfunction

      // Corner order is (col,row), (col+1,row), (col,row+1), (col+1,row+1).
      function void locate(input req_payload_type p, output bit outside,
                           output longint fx, output longint fz,
                           output int unsigned corner [4]);
         longint w, d, s, x, z, xh, zh, ncol, nrow, col, row, c0, c1, r0, r1;
         w = (grid_wide == 0) ? 1 : grid_wide;
         d = (grid_deep == 0) ? 1 : grid_deep;
         s = (grid_sub == 0) ? 1 : grid_sub;
         x = $signed(p.query_x);
         z = $signed(p.query_z);
         outside = (2 * x < -256 * w) || (2 * x > 256 * w) ||
                   (2 * z < -256 * d) || (2 * z > 256 * d);
         fx = 0;
         fz = 0;
         foreach (corner[i]) corner[i] = 0;
         if (!outside) begin
            xh   = (x + w * 128) * s;
            zh   = (z + d * 128) * s;
            col  = xh >>> 8;
            row  = zh >>> 8;
            fx   = xh & 255;
            fz   = zh & 255;
            ncol = w * s;
            nrow = d * s;
            // The far edge stays inside the last cell.
            c0 = (col < ncol - 1) ? col : ncol - 1;
            c1 = (col + 1 < ncol - 1) ? col + 1 : ncol - 1;
            r0 = (row < nrow - 1) ? row : nrow - 1;
            r1 = (row + 1 < nrow - 1) ? row + 1 : nrow - 1;
            corner[0] = 32'((r0 * ncol + c0) % STORE_DEPTH);
            corner[1] = 32'((r0 * ncol + c1) % STORE_DEPTH);
            corner[2] = 32'((r1 * ncol + c0) % STORE_DEPTH);
            corner[3] = 32'((r1 * ncol + c1) % STORE_DEPTH);
         end
      endfunction

      function rsp_payload_type predict_height(req_payload_type p);
         bit              outside;
         longint          fx, fz, ha, hb, hc, hd, h;
         int unsigned     corner [4];
         rsp_payload_type r;
         locate(p, outside, fx, fz, corner);
         r.height       = '0;
         r.out_of_range = outside;
         if (!outside) begin
            ha = sample_mirror[corner[0]];
            hb = sample_mirror[corner[1]];
            hc = sample_mirror[corner[2]];
            hd = sample_mirror[corner[3]];
            // The diagonal runs from (col+1,row) to (col,row+1).
            if (fx + fz > 256)
               h = hd + (((256 - fx) * (hc - hd) + (256 - fz) * (hb - hd)) >>> 8);
            else
               h = ha + ((fx * (hb - ha) + fz * (hc - ha)) >>> 8);
            if (h > HEIGHT_MAX) h = HEIGHT_MAX;
            if (h < HEIGHT_MIN) h = HEIGHT_MIN;
            r.height = h[HEIGHT_W-1:0];
         end
         return r;
      endfunction

      function void note_item(req_payload_type p);
         rsp_payload_type r;
         if (p.opcode == OP_WRITE) begin
            if (p.sample_address < STORE_DEPTH) begin
               sample_mirror[p.sample_address]  = p.sample_height;
               sample_written[p.sample_address] = 1'b1;
            end
            writes_seen++;
         end else begin
            r = predict_height(p);
            expected_heights = {expected_heights, r};
            queries_seen++;
            if (r.out_of_range) outside_seen++;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_heights.size() == 0) begin
            report_mismatch("result transfer with no query waiting");
            return;
         end
         want = expected_heights.pop_front();
         if (got.height !== want.height)
            report_mismatch($sformatf("height %0d, expected %0d", got.height, want.height));
         if (got.out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                      got.out_of_range, want.out_of_range));
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned      sender_idle_pct    = 0;
   int unsigned      receiver_stall_pct = 0;
   int unsigned      cycle_count        = 0;
   height_scoreboard height_sb          = new();

   heightfield_triangle_sampler #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) height_sb.check_result(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] clip_coord(longint v);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [HEIGHT_W-1:0] random_height();
      case ($urandom_range(7))
         0:       return HEIGHT_MAX;
         1:       return HEIGHT_MIN;
         default: return HEIGHT_W'($urandom);
      endcase
   endfunction

   // Valid is only lowered when the sender goes idle, never in the step of a new transfer.
   task automatic send_item(req_payload_type p);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 24 : 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      height_sb.note_item(p);
   endtask

   task automatic write_sample(logic [SAMPLE_ADDR_W-1:0] addr, logic signed [HEIGHT_W-1:0] h);
      req_payload_type p;
      p.opcode         = OP_WRITE;
      p.sample_address = addr;
      p.sample_height  = h;
      p.query_x        = COORD_W'($urandom);
      p.query_z        = COORD_W'($urandom);
      send_item(p);
   endtask

   // Corners that were never written get a sample first, so no query reads an empty entry.
   task automatic send_query(longint x, longint z);
      req_payload_type p;
      bit              outside;
      longint          fx, fz;
      int unsigned     corner [4];
      p.opcode         = OP_QUERY;
      p.sample_address = SAMPLE_ADDR_W'($urandom);
      p.sample_height  = HEIGHT_W'($urandom);
      p.query_x        = clip_coord(x);
      p.query_z        = clip_coord(z);
      height_sb.locate(p, outside, fx, fz, corner);
      if (!outside)
         foreach (corner[i])
            if (!height_sb.sample_written[corner[i]])
               write_sample(SAMPLE_ADDR_W'(corner[i]), random_height());
      send_item(p);
   endtask

   function automatic longint edge_coord(longint e);
      case ($urandom_range(3))
         0:       return -e;
         1:       return e;
         2:       return -e - 1;
         default: return e + 1;
      endcase
   endfunction

   task automatic random_item(longint xe, longint ze);
      int unsigned               kind;
      logic signed [COORD_W-1:0] rx, rz;
      kind = $urandom_range(99);
      rx   = COORD_W'($urandom);
      rz   = COORD_W'($urandom);
      if (kind < 60)
         send_query(longint'($urandom_range(0, 2 * xe)) - xe,
                    longint'($urandom_range(0, 2 * ze)) - ze);
      else if (kind < 72)
         send_query(edge_coord(xe), ($urandom_range(1) == 0) ? edge_coord(ze) : rz);
      else if (kind < 82)
         send_query(rx, rz);
      else
         write_sample(SAMPLE_ADDR_W'($urandom), random_height());
   endtask

   task automatic csr_write(logic [1:0] index, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      height_sb.set_register(index, value);
      @(posedge clock);
   endtask

   // Registers change only with the block idle: all results back, then a margin for
   // a trailing write transfer that has no result of its own.
   task automatic set_grid(int unsigned w, int unsigned d, int unsigned s);
      req_valid <= 1'b0;
      while (height_sb.expected_heights.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      csr_write(REG_CELLS_WIDE, w);
      csr_write(REG_CELLS_DEEP, d);
      csr_write(REG_SUBDIVISIONS, s);
   endtask

   initial begin
      int unsigned w, d, s, item_total, wait_cycles;
      longint      xe, ze;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset grid is 70 by 70 cells with one subdivision per cell, extent +-8960.
      write_sample(0, HEIGHT_MAX);
      write_sample(1, HEIGHT_MIN);
      write_sample(70, HEIGHT_MIN);
      write_sample(71, HEIGHT_MAX);
      send_query(-8960, -8960);
      send_query(-8960 + 200, -8960 + 100);
      send_query(-8960 + 56, -8960 + 200);
      send_query(0, 0);
      send_query(8960, 8960);
      send_query(8960, -8960);
      send_query(-8960, 8960);
      send_query(8961, 0);
      send_query(-8961, 0);
      send_query(0, 8961);
      send_query(0, -8961);
      send_query(32767, 32767);
      send_query(-32768, -32768);

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         case (setting)
            0: begin w = 70;  d = 70;  s = 1;  end
            1: begin w = 1;   d = 1;   s = 1;  end
            2: begin w = 0;   d = 0;   s = 0;  end
            3: begin w = 256; d = 256; s = 16; end
            4: begin w = 5;   d = 3;   s = 4;  end
            5: begin w = 256; d = 1;   s = 1;  end
            6: begin w = 1;   d = 256; s = 16; end
            8: begin
               w = $urandom_range(1, 256);
               d = $urandom_range(1, 256);
               s = $urandom_range(1, 16);
            end
            default: begin
               w = $urandom_range(1, 12);
               d = $urandom_range(1, 12);
               s = $urandom_range(1, 16);
            end
         endcase
         set_grid(w, d, s);
         case (setting % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         xe = 128 * ((w == 0) ? 1 : w);
         ze = 128 * ((d == 0) ? 1 : d);
         // Each setup runs until the running count of input items reaches its share.
         item_total = 40 + 111 * (setting + 1);
         while (height_sb.queries_seen + height_sb.writes_seen < item_total)
            random_item(xe, ze);
      end

      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 20000 && height_sb.expected_heights.size() != 0;
           wait_cycles++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (height_sb.expected_heights.size() != 0)
         height_sb.report_mismatch($sformatf("%0d queries never answered",
                                             height_sb.expected_heights.size()));

      $display("Ran %0d queries (%0d outside the grid) and %0d sample writes",
               height_sb.queries_seen, height_sb.outside_seen, height_sb.writes_seen);
      $display("over %0d grid setups with mixed sender gaps and result stalls; %0d mismatches.",
               SETTING_COUNT, height_sb.mismatches);
      if (height_sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
